// ----- src/ordered_list_insert_delete_search_top_assert.svh -----
// Assertion macros shared by the checkers of the ordered list block.
// No dependencies; included by the checker file.
`ifndef ORDERED_LIST_INSERT_DELETE_SEARCH_TOP_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_SEARCH_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define OLIDS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define OLIDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/olids_pkg.sv -----
// Package of the ordered list block: request and result types, command and
// status codes, and default sizes. No dependencies.
`default_nettype none

package olids_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int CMD_W   = 2;
   localparam int POS_W   = 5;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int FIDX_W  = 4;
   localparam int COUNT_W = 5;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]          command;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic               found;
      logic [FIDX_W-1:0]  found_index;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } seq_done_type;

endpackage

`default_nettype wire

// ----- src/ordered_list_insert_delete_search_top.sv -----
// Flow: an accepted request is registered, then checked by the sequencer; a request that
// is rejected or has an unused command code gives its result from that check. Otherwise
// each entry moved or compared is read in a step state and written or compared in a use state.
// Every moved or compared entry passes the single RAM read and write port of the sequencer.
// Throughput: one request at a time; the next is accepted in the cycle its result shows.
// The result strobe lasts one cycle and cannot be stalled. Synchronous reset empties the list.
`default_nettype none

module ordered_list_insert_delete_search_top import olids_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);

   logic         accept;
   logic         seq_busy;
   req_type      req_ff;
   seq_done_type done;
   logic         rsp_valid_ff;
   rsp_type      rsp_item_ff;

   assign accept = start && !seq_busy;

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
      if (done.valid) begin
         rsp_item_ff <= done.rsp;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= done.valid;
      end
   end

   olids_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_ff),
      .busy   (seq_busy),
      .done   (done)
   );

   assign busy      = seq_busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

// ----- src/olids_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module olids_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/olids_seq.sv -----
// Sequencer of the ordered list: entry count, walking index and the shared
// compare/step unit that moves or checks one entry at a time. Uses olids_pkg, olids_ram.
`default_nettype none

module olids_seq import olids_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire req_type req,
   output logic         busy,
   output seq_done_type done
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_STEP  = 2'd2;
   localparam logic [1:0] S_USE   = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      count_ff, count_in;

   logic               rd_en, wr_en;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic [VALUE_W-1:0] wr_data, rd_data;

   logic [XW-1:0]      pos_x, cnt_x, idx_x, cnt_out_x;
   logic [CW-1:0]      idx_dn;
   logic [CW:0]        idx_up;
   logic               full;

   assign pos_x     = XW'(req.position);
   assign cnt_x     = XW'(count_ff);
   assign idx_x     = XW'(idx_ff);
   assign idx_dn    = idx_ff - CW'(1);
   assign idx_up    = (CW + 1)'(idx_ff) + (CW + 1)'(1);
   assign full      = (count_ff == CW'(DEPTH));
   assign cnt_out_x = XW'(count_in);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      rd_en    = 1'b0;
      rd_addr  = idx_ff[AW-1:0];
      wr_en    = 1'b0;
      wr_addr  = idx_ff[AW-1:0];
      wr_data  = rd_data;
      done.valid           = 1'b0;
      done.rsp.status      = ST_OK;
      done.rsp.found       = 1'b0;
      done.rsp.found_index = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = S_STEP;
            unique case (req.command)
               CMD_INSERT: begin
                  idx_in = count_ff;
                  if (full) begin
                     done.valid      = 1'b1;
                     done.rsp.status = ST_FULL;
                     state_in        = S_IDLE;
                  end else if (pos_x > cnt_x) begin
                     done.valid      = 1'b1;
                     done.rsp.status = ST_BADPOS;
                     state_in        = S_IDLE;
                  end
               end
               CMD_DELETE: begin
                  idx_in = pos_x[CW-1:0];
                  if (count_ff == '0) begin
                     done.valid      = 1'b1;
                     done.rsp.status = ST_EMPTY;
                     state_in        = S_IDLE;
                  end else if (pos_x >= cnt_x) begin
                     done.valid      = 1'b1;
                     done.rsp.status = ST_BADPOS;
                     state_in        = S_IDLE;
                  end
               end
               CMD_SEARCH: begin
                  idx_in = '0;
               end
               default: begin
                  done.valid = 1'b1;
                  state_in   = S_IDLE;
               end
            endcase
         end
         S_STEP: begin
            unique case (req.command)
               CMD_INSERT: begin
                  if (idx_x > pos_x) begin
                     rd_en    = 1'b1;
                     rd_addr  = idx_dn[AW-1:0];
                     state_in = S_USE;
                  end else begin
                     wr_en      = 1'b1;
                     wr_addr    = pos_x[AW-1:0];
                     wr_data    = req.value;
                     count_in   = count_ff + CW'(1);
                     done.valid = 1'b1;
                     state_in   = S_IDLE;
                  end
               end
               CMD_DELETE: begin
                  if (idx_up < (CW + 1)'(count_ff)) begin
                     rd_en    = 1'b1;
                     rd_addr  = idx_up[AW-1:0];
                     state_in = S_USE;
                  end else begin
                     count_in   = count_ff - CW'(1);
                     done.valid = 1'b1;
                     state_in   = S_IDLE;
                  end
               end
               default: begin
                  if (idx_ff < count_ff) begin
                     rd_en    = 1'b1;
                     state_in = S_USE;
                  end else begin
                     done.valid = 1'b1;
                     state_in   = S_IDLE;
                  end
               end
            endcase
         end
         S_USE: begin
            state_in = S_STEP;
            unique case (req.command)
               CMD_INSERT: begin
                  wr_en  = 1'b1;
                  idx_in = idx_dn;
               end
               CMD_DELETE: begin
                  wr_en  = 1'b1;
                  idx_in = idx_up[CW-1:0];
               end
               default: begin
                  if (rd_data == req.value) begin
                     done.valid           = 1'b1;
                     done.rsp.found       = 1'b1;
                     done.rsp.found_index = idx_x[FIDX_W-1:0];
                     state_in             = S_IDLE;
                  end else begin
                     idx_in = idx_up[CW-1:0];
                  end
               end
            endcase
         end
      endcase
      done.rsp.entry_count = cnt_out_x[COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff <= idx_in;
   end

   assign busy = (state_ff != S_IDLE);

   olids_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire

// ----- src/olids_chk.sv -----
// Checker on the ports of the ordered list top level, attached by bind.
// Uses olids_pkg and ordered_list_insert_delete_search_top_assert.svh.
`default_nettype none

`include "ordered_list_insert_delete_search_top_assert.svh"

module olids_chk import olids_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req_item,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_item
);

   logic accepted;
   logic rsp_found;

   assign accepted  = start && !busy;
   assign rsp_found = rsp_valid && rsp_item.found;

   `OLIDS_ASSERT_NEXT(a_accept_busy, clock, reset, accepted, busy, "not busy after request")
   `OLIDS_ASSERT_NEXT(a_accept_no_rsp, clock, reset, accepted, !rsp_valid, "result too early")
   `OLIDS_ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy, "result while busy")
   `OLIDS_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result repeated")
   `OLIDS_ASSERT_SAME(a_found_ok, clock, reset, rsp_found, rsp_item.status == ST_OK, "found error")

endmodule

bind ordered_list_insert_delete_search_top olids_chk u_chk (.*);

`default_nettype wire

// ----- tb/tb_ordered_list_insert_delete_search_top.sv -----
// Self-checking testbench for the ordered list block: a directed table, then random requests
// whose results are predicted from a shadow copy of the list. Depends on olids_pkg and the top.
`timescale 1ns / 100ps

module tb_ordered_list_insert_delete_search_top;
   import olids_pkg::*;

   localparam int LIST_DEPTH = DEPTH_DEFAULT;
   localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 10;
   localparam int RANDOM_PER_PHASE = 145;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      req_type req;
      int      reps;
      bit      pinned;
      rsp_type want;
   } script_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   logic signed [VALUE_W-1:0] shadow_list [LIST_DEPTH];
   int                        shadow_len;
   rsp_type                   expected_q [$];
   int                        mismatch_count;
   int                        idle_pct;
   script_row_type            script [$];
   int                        idle_pct_list [3] = '{14, 75, 0};

   ordered_list_insert_delete_search_top #(.DEPTH(LIST_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always #6 clock = ~clock;

   // Applies one request to the shadow list and returns the result it should produce.
   function automatic rsp_type apply_command(input req_type r);
      rsp_type res;
      int      i;
      int      pos;
      res = '0;
      res.status = ST_OK;
      pos = int'(r.position);
      case (r.command)
         CMD_INSERT: begin
            if (shadow_len >= LIST_DEPTH) begin
               res.status = ST_FULL;
            end else if (pos > shadow_len) begin
               res.status = ST_BADPOS;
            end else begin
               for (i = shadow_len; i > pos; i--) shadow_list[i] = shadow_list[i - 1];
               shadow_list[pos] = r.value;
               shadow_len++;
            end
         end
         CMD_DELETE: begin
            if (shadow_len == 0) begin
               res.status = ST_EMPTY;
            end else if (pos >= shadow_len) begin
               res.status = ST_BADPOS;
            end else begin
               for (i = pos; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
               shadow_len--;
            end
         end
         CMD_SEARCH: begin
            for (i = 0; i < shadow_len && !res.found; i++) begin
               if (shadow_list[i] == r.value) begin
                  res.found = 1'b1;
                  res.found_index = i[FIDX_W-1:0];
               end
            end
         end
         default: begin
         end
      endcase
      res.entry_count = shadow_len[COUNT_W-1:0];
      return res;
   endfunction

   function automatic script_row_type mk_row(input logic [CMD_W-1:0] cmd, input int pos,
                                             input logic [VALUE_W-1:0] val, input int reps,
                                             input bit pinned, input logic [STAT_W-1:0] st,
                                             input bit fnd, input int fidx, input int cnt);
      script_row_type row;
      row.req.command = cmd;
      row.req.position = pos[POS_W-1:0];
      row.req.value = val;
      row.reps = reps;
      row.pinned = pinned;
      row.want.status = st;
      row.want.found = fnd;
      row.want.found_index = fidx[FIDX_W-1:0];
      row.want.entry_count = cnt[COUNT_W-1:0];
      return row;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(99);
      if (sel < 35) return VALUE_W'($urandom_range(7));
      if (sel < 45) begin
         case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
         endcase
      end
      return $urandom;
   endfunction

   // Mostly legal requests built from the current list, with some unconstrained noise.
   function automatic req_type pick_request();
      req_type r;
      int      sel;
      r.value = pick_value();
      r.position = POS_W'($urandom_range(LIST_DEPTH));
      if ($urandom_range(99) < 18) begin
         r.command = CMD_W'($urandom_range(3));
         return r;
      end
      sel = $urandom_range(99);
      if (shadow_len == 0 || (shadow_len < LIST_DEPTH && sel < 42)) begin
         r.command = CMD_INSERT;
         r.position = POS_W'($urandom_range(shadow_len));
      end else if (sel < 72) begin
         r.command = CMD_DELETE;
         r.position = POS_W'($urandom_range(shadow_len - 1));
      end else begin
         r.command = CMD_SEARCH;
         if ($urandom_range(99) < 60) r.value = shadow_list[$urandom_range(shadow_len - 1)];
      end
      return r;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t ns: %s", $time, msg);
   endtask

   task automatic send_request(input req_type r, input bit pinned, input rsp_type want);
      rsp_type predicted;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      predicted = apply_command(r);
      expected_q.push_back(pinned ? want : predicted);
   endtask

   task automatic wait_for_drain();
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            note_mismatch($sformatf("unexpected result %p", rsp_item));
         end else begin
            want = expected_q.pop_front();
            if (rsp_item.status !== want.status || rsp_item.found !== want.found ||
                rsp_item.found_index !== want.found_index ||
                rsp_item.entry_count !== want.entry_count) begin
               note_mismatch($sformatf("expected %p, got %p", want, rsp_item));
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      shadow_len = 0;
      mismatch_count = 0;
      idle_pct = 0;
      foreach (shadow_list[i]) shadow_list[i] = '0;

      script.push_back(mk_row(CMD_DELETE, 0, 32'h0, 1, 1, ST_EMPTY, 0, 0, 0));
      script.push_back(mk_row(CMD_DELETE, 16, 32'h0, 1, 1, ST_EMPTY, 0, 0, 0));
      script.push_back(mk_row(CMD_SEARCH, 0, 32'h0, 1, 1, ST_OK, 0, 0, 0));
      script.push_back(mk_row(CMD_INSERT, 1, 32'd123, 1, 1, ST_BADPOS, 0, 0, 0));
      script.push_back(mk_row(CMD_INSERT, 0, 32'h8000_0000, 1, 1, ST_OK, 0, 0, 1));
      script.push_back(mk_row(CMD_INSERT, 1, 32'h7FFF_FFFF, 1, 1, ST_OK, 0, 0, 2));
      script.push_back(mk_row(CMD_INSERT, 0, 32'hFFFF_FFFF, 1, 1, ST_OK, 0, 0, 3));
      script.push_back(mk_row(CMD_SEARCH, 16, 32'h7FFF_FFFF, 1, 1, ST_OK, 1, 2, 3));
      script.push_back(mk_row(CMD_SEARCH, 0, 32'h8000_0000, 1, 1, ST_OK, 1, 1, 3));
      script.push_back(mk_row(CMD_UNUSED, 16, 32'hFFFF_FFFF, 1, 1, ST_OK, 0, 0, 3));
      script.push_back(mk_row(CMD_DELETE, 3, 32'h0, 1, 1, ST_BADPOS, 0, 0, 3));
      script.push_back(mk_row(CMD_INSERT, 4, 32'h1, 1, 1, ST_BADPOS, 0, 0, 3));
      script.push_back(mk_row(CMD_DELETE, 1, 32'h0, 1, 1, ST_OK, 0, 0, 2));
      script.push_back(mk_row(CMD_INSERT, 1, 32'd5, 1, 0, ST_OK, 0, 0, 0));
      script.push_back(mk_row(CMD_INSERT, 1, 32'd5, 1, 0, ST_OK, 0, 0, 0));
      script.push_back(mk_row(CMD_SEARCH, 0, 32'd5, 1, 1, ST_OK, 1, 1, 4));
      script.push_back(mk_row(CMD_INSERT, 0, 32'h5555_5555, 12, 0, ST_OK, 0, 0, 0));
      script.push_back(mk_row(CMD_INSERT, 16, 32'h2, 1, 1, ST_FULL, 0, 0, 16));
      script.push_back(mk_row(CMD_INSERT, 0, 32'h3, 1, 1, ST_FULL, 0, 0, 16));
      script.push_back(mk_row(CMD_SEARCH, 0, 32'h7FFF_FFFF, 1, 1, ST_OK, 1, 15, 16));
      script.push_back(mk_row(CMD_SEARCH, 0, 32'h2AAA_AAAA, 1, 1, ST_OK, 0, 0, 16));
      script.push_back(mk_row(CMD_DELETE, 16, 32'h0, 1, 1, ST_BADPOS, 0, 0, 16));
      script.push_back(mk_row(CMD_DELETE, 15, 32'h0, 1, 1, ST_OK, 0, 0, 15));
      script.push_back(mk_row(CMD_DELETE, 0, 32'h0, 1, 0, ST_OK, 0, 0, 0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[n]) begin
         repeat (script[n].reps) send_request(script[n].req, script[n].pinned, script[n].want);
      end
      start <= 1'b0;
      wait_for_drain();

      foreach (idle_pct_list[p]) begin
         idle_pct = idle_pct_list[p];
         repeat (RANDOM_PER_PHASE) send_request(pick_request(), 1'b0, '0);
         start <= 1'b0;
         wait_for_drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- ordered_list_insert_delete_search_top.f -----
+incdir+src
src/olids_pkg.sv
src/olids_ram.sv
src/olids_seq.sv
src/ordered_list_insert_delete_search_top.sv
src/olids_chk.sv
tb/tb_ordered_list_insert_delete_search_top.sv
